@@ rtl/core/tld_pkg.sv @@
// ----------------------------------------------------------------------------
// tld_pkg
// Shared constants, types and echo byte table of the terminal line discipline.
// ----------------------------------------------------------------------------
`default_nettype none

package tld_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned LINE_DEPTH = 1024;

  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam int unsigned RING_CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned LINE_AW = $clog2(LINE_DEPTH);
  localparam int unsigned LINE_LW = $clog2(LINE_DEPTH + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FILL_W = 13;
  localparam int unsigned SIG_W  = 2;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 8;

  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_UC_C  = 8'h43;

  localparam logic [BYTE_W-1:0] RST_INTR_CHAR = 8'h03;
  localparam logic [BYTE_W-1:0] RST_QUIT_CHAR = 8'h1C;
  localparam logic [BYTE_W-1:0] RST_ERASE_CHAR = 8'h08;
  localparam logic [BYTE_W-1:0] RST_SUSP_CHAR = 8'h1A;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SIGNALS_ENABLED = 3'd0,
    CFG_CANONICAL_MODE  = 3'd1,
    CFG_ECHO_ENABLED    = 3'd2,
    CFG_INTERRUPT_CHAR  = 3'd3,
    CFG_QUIT_CHAR       = 3'd4,
    CFG_ERASE_CHAR      = 3'd5,
    CFG_SUSPEND_CHAR    = 3'd6
  } cfg_idx_e;

  typedef enum logic [SIG_W-1:0] {
    SIG_NONE = 2'd0,
    SIG_INTR = 2'd1,
    SIG_QUIT = 2'd2,
    SIG_STOP = 2'd3
  } sig_code_e;

  typedef enum logic [2:0] {
    ECHO_NONE  = 3'd0,
    ECHO_SIG   = 3'd1,
    ECHO_CHAR  = 3'd2,
    ECHO_ERASE = 3'd3,
    ECHO_NL    = 3'd4
  } echo_kind_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] echo_byte;
    logic              echo_valid;
    logic [SIG_W-1:0]  signal_code;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              line_end;
    logic [FILL_W-1:0] ring_fill;
    logic              last;
  } res_t;

  // number of echo bytes minus one
  function automatic logic [1:0] echo_last_idx(echo_kind_e kind);
    logic [1:0] n;
    unique case (kind)
      ECHO_SIG:   n = 2'd3;
      ECHO_ERASE: n = 2'd2;
      ECHO_NL:    n = 2'd1;
      default:    n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] echo_char(echo_kind_e kind, logic [1:0] k,
                                                  logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] b;
    b = '0;
    unique case (kind)
      ECHO_SIG: begin
        unique case (k)
          2'd0:    b = CH_CARET;
          2'd1:    b = CH_UC_C;
          2'd2:    b = CH_CR;
          default: b = CH_LF;
        endcase
      end
      ECHO_ERASE: b = (k == 2'd1) ? CH_SP : CH_BS;
      ECHO_NL:    b = (k == 2'd0) ? CH_CR : CH_LF;
      ECHO_CHAR:  b = c;
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tld_if.sv @@
// ----------------------------------------------------------------------------
// tld_in_if / tld_out_if
// Request and result channels of the terminal line discipline.
// ----------------------------------------------------------------------------
`default_nettype none

interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key_byte;

  modport source (output valid, output req_type, output key_byte, input ready);
  modport sink (input valid, input req_type, input key_byte, output ready);
endinterface

interface tld_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic        echo_valid;
  logic [1:0]  signal_code;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic        line_end;
  logic [12:0] ring_fill;
  logic        last;

  modport source (output valid, output echo_byte, output echo_valid, output signal_code,
                  output read_byte, output read_valid, output line_end,
                  output ring_fill, output last, input ready);
  modport sink (input valid, input echo_byte, input echo_valid, input signal_code,
                input read_byte, input read_valid, input line_end,
                input ring_fill, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tld_ram.sv @@
// ----------------------------------------------------------------------------
// tld_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/tld_ring.sv @@
// ----------------------------------------------------------------------------
// tld_ring
// Readable byte ring: storage, head and tail pointers and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module tld_ring (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tld_pkg::ring_req_t             req_i,
  output      logic [tld_pkg::RING_CW-1:0]    count_o,
  output      logic [tld_pkg::BYTE_W-1:0]     rdata_o
);
  import tld_pkg::*;

  logic [RING_AW-1:0] head_q, head_d;
  logic [RING_AW-1:0] tail_q, tail_d;
  logic [RING_CW-1:0] count_q, count_d;
  logic               push_ok;
  logic               pop_ok;

  assign push_ok = req_i.push && (count_q < RING_CW'(RING_DEPTH));
  assign pop_ok  = req_i.pop && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_ok) begin
      tail_d  = (tail_q == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_q + RING_AW'(1);
      count_d = count_q + RING_CW'(1);
    end else if (pop_ok) begin
      head_d  = (head_q == RING_AW'(RING_DEPTH - 1)) ? '0 : head_q + RING_AW'(1);
      count_d = count_q - RING_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  tld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (tail_q),
    .wdata_i (req_i.wdata),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

  assign count_o = count_q;

endmodule

`default_nettype wire

@@ rtl/core/terminal_line_discipline.sv @@
// ----------------------------------------------------------------------------
// terminal_line_discipline
// Terminal input line discipline: signal keys, raw pass-through, canonical
// line editing with commit into the readable ring, and byte reads.
// A key is decoded on acceptance and then gives one to four results.
// A read goes accept, ring RAM read, result; an empty ring skips the RAM read.
// A newline key commits the line into the ring before its results.
// The next request is taken once the last result is registered; result stalls delay it.
// Reset loads default config and clears pointers and counts; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_discipline (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tld_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [tld_pkg::CFG_DW-1:0]  cfg_data_i,
  tld_in_if.sink                           in_i,
  tld_out_if.source                        out_o
);
  import tld_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_COMMIT = 5'b00010,
    S_POP    = 5'b00100,
    S_EMIT   = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic              sig_en_q, canon_q, echo_en_q;
  logic [BYTE_W-1:0] intr_char_q, quit_char_q, erase_char_q, susp_char_q;

  logic [LINE_LW-1:0] line_cnt_q, line_cnt_d;
  logic [LINE_LW-1:0] idx_q, idx_d;
  logic               pend_q, pend_d;
  echo_kind_e         kind_q, kind_d;
  logic [1:0]         nres_q, nres_d;
  logic [1:0]         k_q, k_d;
  logic               echo_on_q, echo_on_d;
  logic [SIG_W-1:0]   sig_q, sig_d;
  logic [BYTE_W-1:0]  key_q, key_d;
  logic [BYTE_W-1:0]  rbyte_q, rbyte_d;
  logic               rvalid_q, rvalid_d;
  res_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic [BYTE_W-1:0]  c;
  sig_code_e          sig_c;
  echo_kind_e         kind_c;
  logic               line_we;
  logic [BYTE_W-1:0]  line_wdata;
  logic [BYTE_W-1:0]  line_rdata;
  ring_req_t          ring_req;
  logic [RING_CW-1:0] ring_count;
  logic [BYTE_W-1:0]  ring_rdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.key_byte;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_en_q     <= 1'b1;
      canon_q      <= 1'b1;
      echo_en_q    <= 1'b1;
      intr_char_q  <= RST_INTR_CHAR;
      quit_char_q  <= RST_QUIT_CHAR;
      erase_char_q <= RST_ERASE_CHAR;
      susp_char_q  <= RST_SUSP_CHAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIGNALS_ENABLED: sig_en_q     <= cfg_data_i[0];
        CFG_CANONICAL_MODE:  canon_q      <= cfg_data_i[0];
        CFG_ECHO_ENABLED:    echo_en_q    <= cfg_data_i[0];
        CFG_INTERRUPT_CHAR:  intr_char_q  <= cfg_data_i;
        CFG_QUIT_CHAR:       quit_char_q  <= cfg_data_i;
        CFG_ERASE_CHAR:      erase_char_q <= cfg_data_i;
        CFG_SUSPEND_CHAR:    susp_char_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sig_c = SIG_NONE;
    if (sig_en_q) begin
      priority if (c == intr_char_q) sig_c = SIG_INTR;
      else if (c == quit_char_q)     sig_c = SIG_QUIT;
      else if (c == susp_char_q)     sig_c = SIG_STOP;
      else                           sig_c = SIG_NONE;
    end
  end

  always_comb begin
    state_d     = state_q;
    line_cnt_d  = line_cnt_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    kind_d      = kind_q;
    nres_d      = nres_q;
    k_d         = k_q;
    echo_on_d   = echo_on_q;
    sig_d       = sig_q;
    key_d       = key_q;
    rbyte_d     = rbyte_q;
    rvalid_d    = rvalid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_c      = ECHO_NONE;
    line_we     = 1'b0;
    line_wdata  = c;
    ring_req    = '{push: 1'b0, pop: 1'b0, wdata: c};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          k_d      = '0;
          key_d    = c;
          rbyte_d  = '0;
          rvalid_d = 1'b0;
          state_d  = S_EMIT;
          if (in_i.req_type) begin
            sig_d     = SIG_NONE;
            kind_d    = ECHO_NONE;
            echo_on_d = 1'b0;
            nres_d    = '0;
            if (ring_count != '0) begin
              ring_req.pop = 1'b1;
              state_d      = S_POP;
            end
          end else begin
            sig_d = sig_c;
            priority if (sig_c != SIG_NONE) begin
              line_cnt_d = '0;
              kind_c     = ECHO_SIG;
            end else if (!canon_q) begin
              ring_req.push = 1'b1;
              kind_c        = ECHO_CHAR;
            end else if (c == erase_char_q || c == CH_DEL) begin
              if (line_cnt_q != '0) begin
                line_cnt_d = line_cnt_q - LINE_LW'(1);
                kind_c     = ECHO_ERASE;
              end
            end else if (c == CH_CR || c == CH_LF) begin
              if (line_cnt_q < LINE_LW'(LINE_DEPTH)) begin
                line_we    = 1'b1;
                line_wdata = CH_LF;
                line_cnt_d = line_cnt_q + LINE_LW'(1);
              end
              kind_c  = ECHO_NL;
              idx_d   = '0;
              state_d = S_COMMIT;
            end else begin
              if (line_cnt_q < LINE_LW'(LINE_DEPTH)) begin
                line_we    = 1'b1;
                line_cnt_d = line_cnt_q + LINE_LW'(1);
                kind_c     = ECHO_CHAR;
              end
            end
            kind_d    = kind_c;
            echo_on_d = echo_en_q && (kind_c != ECHO_NONE);
            nres_d    = echo_on_d ? echo_last_idx(kind_c) : 2'd0;
          end
        end
      end
      S_COMMIT: begin
        if (pend_q) begin
          ring_req.push  = 1'b1;
          ring_req.wdata = line_rdata;
        end
        if (idx_q < line_cnt_q) begin
          idx_d  = idx_q + LINE_LW'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          line_cnt_d = '0;
          state_d    = S_EMIT;
        end
      end
      S_POP: begin
        rbyte_d  = ring_rdata;
        rvalid_d = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d       = 1'b1;
          out_d.echo_byte   = echo_on_q ? echo_char(kind_q, k_q, key_q) : '0;
          out_d.echo_valid  = echo_on_q;
          out_d.signal_code = sig_q;
          out_d.read_byte   = rbyte_q;
          out_d.read_valid  = rvalid_q;
          out_d.line_end    = rvalid_q && canon_q && (rbyte_q == CH_LF);
          out_d.ring_fill   = FILL_W'(ring_count);
          out_d.last        = (k_q == nres_q);
          if (k_q == nres_q) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      line_cnt_q  <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      kind_q      <= ECHO_NONE;
      nres_q      <= '0;
      k_q         <= '0;
      echo_on_q   <= 1'b0;
      sig_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_cnt_q  <= line_cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      kind_q      <= kind_d;
      nres_q      <= nres_d;
      k_q         <= k_d;
      echo_on_q   <= echo_on_d;
      sig_q       <= sig_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    rbyte_q <= rbyte_d;
    out_q   <= out_d;
  end

  tld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_cnt_q[LINE_AW-1:0]),
    .wdata_i (line_wdata),
    .raddr_i (idx_q[LINE_AW-1:0]),
    .rdata_o (line_rdata)
  );

  tld_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ring_req),
    .count_o (ring_count),
    .rdata_o (ring_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.echo_byte   = out_q.echo_byte;
  assign out_o.echo_valid  = out_q.echo_valid;
  assign out_o.signal_code = out_q.signal_code;
  assign out_o.read_byte   = out_q.read_byte;
  assign out_o.read_valid  = out_q.read_valid;
  assign out_o.line_end    = out_q.line_end;
  assign out_o.ring_fill   = out_q.ring_fill;
  assign out_o.last        = out_q.last;

endmodule

`default_nettype wire

@@ verif/tld_checker.sv @@
// ----------------------------------------------------------------------------
// tld_checker
// Watches the config port and both channels of the terminal line discipline,
// keeps its own copy of the line buffer, read ring and settings, works out
// the results of every accepted request and compares each returned result
// field by field with the oldest one still due.
// ----------------------------------------------------------------------------

module tld_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tld_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [tld_pkg::CFG_DW-1:0] cfg_data_i,
  tld_in_if                          req_i,
  tld_out_if                         res_i,
  output int unsigned                fail_cnt_o,
  output int unsigned                due_cnt_o
);

  import tld_pkg::*;

  logic                sig_en, canon, echo_en;
  logic [BYTE_W-1:0]   intr_ch, quit_ch, erase_ch, susp_ch;
  logic [BYTE_W-1:0]   line_mem [LINE_DEPTH];
  int unsigned         line_cnt;
  logic [BYTE_W-1:0]   ring_mem [RING_DEPTH];
  logic [RING_AW-1:0]  ring_rd, ring_wr;
  int unsigned         ring_cnt;
  res_t                due_res [$];

  // full ring drops the byte
  function automatic void ring_push(logic [BYTE_W-1:0] b);
    if (ring_cnt < RING_DEPTH) begin
      ring_mem[ring_wr] = b;
      ring_wr = ring_wr + 1'b1;
      ring_cnt++;
    end
  endfunction

  function automatic void read_effect();
    res_t r;
    r = '0;
    if (ring_cnt != 0) begin
      r.read_byte  = ring_mem[ring_rd];
      r.read_valid = 1'b1;
      r.line_end   = canon && (ring_mem[ring_rd] == CH_LF);
      ring_rd = ring_rd + 1'b1;
      ring_cnt--;
    end
    r.ring_fill = FILL_W'(ring_cnt);
    r.last      = 1'b1;
    due_res.push_back(r);
  endfunction

  function automatic void key_effect(logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] echo_seq [4];
    int unsigned       n, k;
    sig_code_e         sig;
    res_t              r;
    n = 0;
    sig = SIG_NONE;
    echo_seq = '{default: '0};
    if (sig_en) begin
      if (c == intr_ch) sig = SIG_INTR;
      else if (c == quit_ch) sig = SIG_QUIT;
      else if (c == susp_ch) sig = SIG_STOP;
    end
    if (sig != SIG_NONE) begin
      line_cnt = 0;
      echo_seq = '{CH_CARET, CH_UC_C, CH_CR, CH_LF};
      n = 4;
    end else if (!canon) begin
      ring_push(c);
      echo_seq[0] = c;
      n = 1;
    end else if (c == erase_ch || c == CH_DEL) begin
      if (line_cnt != 0) begin
        line_cnt--;
        echo_seq[0] = CH_BS;
        echo_seq[1] = CH_SP;
        echo_seq[2] = CH_BS;
        n = 3;
      end
    end else if (c == CH_CR || c == CH_LF) begin
      // full line commits without the newline
      if (line_cnt < LINE_DEPTH) begin
        line_mem[line_cnt] = CH_LF;
        line_cnt++;
      end
      echo_seq[0] = CH_CR;
      echo_seq[1] = CH_LF;
      n = 2;
      for (k = 0; k < line_cnt; k++) ring_push(line_mem[k]);
      line_cnt = 0;
    end else if (line_cnt < LINE_DEPTH) begin
      line_mem[line_cnt] = c;
      line_cnt++;
      echo_seq[0] = c;
      n = 1;
    end
    if (!echo_en) n = 0;
    r = '0;
    r.signal_code = sig;
    r.ring_fill   = FILL_W'(ring_cnt);
    if (n == 0) begin
      r.last = 1'b1;
      due_res.push_back(r);
    end else begin
      for (k = 0; k < n; k++) begin
        r.echo_byte  = echo_seq[k];
        r.echo_valid = 1'b1;
        r.last       = (k == n - 1);
        due_res.push_back(r);
      end
    end
  endfunction

  always @(posedge clk_i) begin : watch
    res_t got, want;
    if (!rst_ni) begin
      sig_en   = 1'b1;
      canon    = 1'b1;
      echo_en  = 1'b1;
      intr_ch  = RST_INTR_CHAR;
      quit_ch  = RST_QUIT_CHAR;
      erase_ch = RST_ERASE_CHAR;
      susp_ch  = RST_SUSP_CHAR;
      line_cnt = 0;
      ring_rd  = '0;
      ring_wr  = '0;
      ring_cnt = 0;
      due_res.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SIGNALS_ENABLED: sig_en   = cfg_data_i[0];
          CFG_CANONICAL_MODE:  canon    = cfg_data_i[0];
          CFG_ECHO_ENABLED:    echo_en  = cfg_data_i[0];
          CFG_INTERRUPT_CHAR:  intr_ch  = cfg_data_i;
          CFG_QUIT_CHAR:       quit_ch  = cfg_data_i;
          CFG_ERASE_CHAR:      erase_ch = cfg_data_i;
          CFG_SUSPEND_CHAR:    susp_ch  = cfg_data_i;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type) read_effect();
        else key_effect(req_i.key_byte);
      end
      if (res_i.valid && res_i.ready) begin
        got.echo_byte   = res_i.echo_byte;
        got.echo_valid  = res_i.echo_valid;
        got.signal_code = res_i.signal_code;
        got.read_byte   = res_i.read_byte;
        got.read_valid  = res_i.read_valid;
        got.line_end    = res_i.line_end;
        got.ring_fill   = res_i.ring_fill;
        got.last        = res_i.last;
        if (due_res.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t: extra result echo %h/%b sig %0d read %h/%b end %b fill %0d last %b",
                     $realtime, got.echo_byte, got.echo_valid, got.signal_code,
                     got.read_byte, got.read_valid, got.line_end, got.ring_fill, got.last);
          fail_cnt_o++;
        end else begin
          want = due_res.pop_front();
          if (got.echo_byte !== want.echo_byte || got.echo_valid !== want.echo_valid ||
              got.signal_code !== want.signal_code || got.read_byte !== want.read_byte ||
              got.read_valid !== want.read_valid || got.line_end !== want.line_end ||
              got.ring_fill !== want.ring_fill || got.last !== want.last) begin
            if (fail_cnt_o < 10) begin
              $display("%0t: mismatch exp echo %h/%b sig %0d read %h/%b end %b fill %0d last %b",
                       $realtime, want.echo_byte, want.echo_valid, want.signal_code,
                       want.read_byte, want.read_valid, want.line_end, want.ring_fill,
                       want.last);
              $display("%0t:          got echo %h/%b sig %0d read %h/%b end %b fill %0d last %b",
                       $realtime, got.echo_byte, got.echo_valid, got.signal_code,
                       got.read_byte, got.read_valid, got.line_end, got.ring_fill,
                       got.last);
            end
            fail_cnt_o++;
          end
        end
      end
    end
    due_cnt_o = due_res.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the terminal line discipline: a directed pass over editing,
// signal and read cases, then mixed typed lines, reads, signal keys and noise
// under several settings with random gaps and result stalls.
// ----------------------------------------------------------------------------

module tb;

  import tld_pkg::*;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              accept_en = 1'b0;
  logic              idle_on;
  logic              stall_on = 1'b1;
  int unsigned       hold = 0;
  int unsigned       n_sent;
  int unsigned       fail_cnt, due_cnt;
  logic [7:0]        cur_intr, cur_quit, cur_erase, cur_susp;

  tld_in_if  req_if ();
  tld_out_if res_if ();

  assign res_if.ready = accept_en;

  terminal_line_discipline dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_if),
    .out_o     (res_if)
  );

  tld_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .res_i     (res_if),
    .fail_cnt_o(fail_cnt),
    .due_cnt_o (due_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stall, drawn per result
  always @(posedge clk_i) begin : res_pacing
    int unsigned draw;
    if (!rst_ni) begin
      accept_en <= 1'b0;
      hold <= 0;
    end else if (res_if.valid && res_if.ready) begin
      draw = stall_on ? $urandom_range(0, 5) : 0;
      hold <= draw;
      accept_en <= (draw == 0);
    end else if (hold != 0) begin
      hold <= hold - 1;
      accept_en <= (hold == 1);
    end else begin
      accept_en <= 1'b1;
    end
  end

  task automatic send_req(input logic rd, input logic [7:0] kb);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rd;
    req_if.key_byte <= kb;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (due_cnt != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic sig, input logic canon, input logic echo,
                            input logic [7:0] ci, input logic [7:0] cq,
                            input logic [7:0] ce, input logic [7:0] cs);
    write_reg(CFG_SIGNALS_ENABLED, {7'd0, sig});
    write_reg(CFG_CANONICAL_MODE, {7'd0, canon});
    write_reg(CFG_ECHO_ENABLED, {7'd0, echo});
    write_reg(CFG_INTERRUPT_CHAR, ci);
    write_reg(CFG_QUIT_CHAR, cq);
    write_reg(CFG_ERASE_CHAR, ce);
    write_reg(CFG_SUSPEND_CHAR, cs);
    cur_intr  = ci;
    cur_quit  = cq;
    cur_erase = ce;
    cur_susp  = cs;
  endtask

  // typed lines with edits, read bursts, signal keys and noise
  task automatic run_mix(input int unsigned n_items);
    int unsigned stop, len, i, pick;
    stop = n_sent + n_items;
    while (n_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        len = $urandom_range(0, 10);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 5) == 0)
            send_req(REQ_KEY, $urandom_range(0, 1) ? CH_DEL : cur_erase);
          else
            send_req(REQ_KEY, 8'($urandom_range(8'h20, 8'h7E)));
        end
        send_req(REQ_KEY, $urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (pick < 7) begin
        len = $urandom_range(1, 16);
        repeat (len) send_req(REQ_READ, 8'($urandom()));
      end else if (pick == 7) begin
        len = $urandom_range(0, 2);
        send_req(REQ_KEY, (len == 0) ? cur_intr : (len == 1) ? cur_quit : cur_susp);
      end else begin
        send_req(1'($urandom()), 8'($urandom()));
      end
      if ($urandom_range(0, 30) == 0) drain();
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_KEY;
    req_if.key_byte = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    idle_on    = 1'b1;
    n_sent     = 0;
    cur_intr   = RST_INTR_CHAR;
    cur_quit   = RST_QUIT_CHAR;
    cur_erase  = RST_ERASE_CHAR;
    cur_susp   = RST_SUSP_CHAR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // editing, commit, signals and reads under reset settings
    send_req(REQ_READ, 8'h00);
    send_req(REQ_KEY, 8'h00);
    send_req(REQ_KEY, 8'hFF);
    send_req(REQ_KEY, 8'h61);
    send_req(REQ_KEY, RST_ERASE_CHAR);
    send_req(REQ_KEY, CH_DEL);
    send_req(REQ_KEY, CH_DEL);
    send_req(REQ_KEY, CH_DEL);
    send_req(REQ_KEY, 8'h68);
    send_req(REQ_KEY, 8'h69);
    send_req(REQ_KEY, CH_CR);
    repeat (4) send_req(REQ_READ, 8'hFF);
    send_req(REQ_KEY, 8'h78);
    send_req(REQ_KEY, RST_INTR_CHAR);
    send_req(REQ_KEY, RST_QUIT_CHAR);
    send_req(REQ_KEY, RST_SUSP_CHAR);
    send_req(REQ_KEY, 8'h79);
    send_req(REQ_KEY, CH_LF);
    repeat (3) send_req(REQ_READ, 8'h00);
    drain();

    for (p = 0; p < 7; p++) begin
      idle_on = (p % 3 != 2);
      stall_on <= (p % 4 != 1);
      case (p)
        0: set_config(1'b1, 1'b1, 1'b1, RST_INTR_CHAR, RST_QUIT_CHAR, RST_ERASE_CHAR,
                      RST_SUSP_CHAR);
        1: set_config(1'b1, 1'b0, 1'b1, RST_INTR_CHAR, RST_QUIT_CHAR, RST_ERASE_CHAR,
                      RST_SUSP_CHAR);
        2: set_config(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        3: set_config(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: set_config(1'($urandom()), 1'($urandom()), 1'($urandom()),
                            8'($urandom()), 8'($urandom()), 8'($urandom()),
                            8'($urandom()));
      endcase
      run_mix(50);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
